### design/pbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_pkg
// Shared types, constants and helper functions of the blend mode compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package pbm_pkg;

    localparam int NUM_STAGES = 15;

    // widths of the pipelined restoring divider
    localparam int DIV_NW = 35;
    localparam int DIV_DW = 25;

    localparam logic [3:0] MODE_NORMAL   = 4'd0;
    localparam logic [3:0] MODE_MULTIPLY = 4'd1;
    localparam logic [3:0] MODE_ADD      = 4'd2;
    localparam logic [3:0] MODE_OVERLAY  = 4'd3;
    localparam logic [3:0] MODE_SCREEN   = 4'd4;
    localparam logic [3:0] MODE_DARKEN   = 4'd5;
    localparam logic [3:0] MODE_LIGHTEN  = 4'd6;
    localparam logic [3:0] MODE_DODGE    = 4'd7;
    localparam logic [3:0] MODE_BURN     = 4'd8;
    localparam logic [3:0] MODE_HARD     = 4'd9;
    localparam logic [3:0] MODE_SOFT     = 4'd10;
    localparam logic [3:0] MODE_DIFF     = 4'd11;
    localparam logic [3:0] MODE_EXCL     = 4'd12;
    localparam logic [3:0] MODE_ERASE    = 4'd13;

    localparam logic REG_LAYER_MODE = 1'b0;
    localparam logic REG_OPACITY    = 1'b1;

    localparam logic [3:0] RESET_LAYER_MODE = MODE_NORMAL;
    localparam logic [7:0] RESET_OPACITY    = 8'd255;

    typedef struct packed {
        logic [7:0] src_red;
        logic [7:0] src_green;
        logic [7:0] src_blue;
        logic [7:0] src_alpha;
        logic [7:0] dst_red;
        logic [7:0] dst_green;
        logic [7:0] dst_blue;
        logic [7:0] dst_alpha;
    } pbm_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
    } pbm_out_t;

    typedef logic [7:0] sqrt_lut_t [256];

    // round(sqrt(255*i)), built at elaboration
    function automatic sqrt_lut_t build_sqrt_lut();
        sqrt_lut_t t;
        int v;
        int r;
        for (int i = 0; i < 256; i++) begin
            v = 255 * i;
            r = 0;
            for (int k = 1; k < 256; k++) begin
                if (k * k <= v) begin
                    r = k;
                end
            end
            if (v - r * r > r) begin
                r = r + 1;
            end
            t[i] = 8'(r);
        end
        return t;
    endfunction

    localparam sqrt_lut_t SQRT_LUT = build_sqrt_lut();

    // floor(y/255) by reciprocal multiply and one correction step
    function automatic logic [7:0] div255(input logic [16:0] y);
        logic [32:0] prod;
        logic [7:0]  q;
        logic [16:0] t;
        logic [16:0] r;
        prod = 33'(y) * 33'd32896;
        q    = prod[30:23];
        t    = {1'b0, q, 8'b0} - 17'(q);
        r    = y - t;
        if (r >= 17'd255) begin
            q = q + 8'd1;
        end
        return q;
    endfunction

    function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

`default_nettype wire

### design/pbm_flow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_flow
// Valid bits and per-stage load enables of the compositor pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_flow import pbm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [NUM_STAGES:1]   load
);

    logic [NUM_STAGES:1] valid_reg;

    // a stage may load when m_ready is high or when it or any stage after it holds a bubble
    always_comb begin
        for (int k = 1; k <= NUM_STAGES; k++) begin
            load[k] = m_ready | ~(&(valid_reg | NUM_STAGES'((1 << (k - 1)) - 1)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load[1]) begin
                valid_reg[1] <= s_valid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_ready = load[1];
    assign m_valid = valid_reg[NUM_STAGES];

endmodule

`default_nettype wire

### design/pbm_mix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_mix
// Four-stage front end of one color channel: forms the blend quotient
// operands, or a direct blend value for the modes that need no division.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_mix import pbm_pkg::*; (
    input  logic              aclk,
    input  logic [4:1]        load,
    input  logic [3:0]        mode_in,
    input  logic [7:0]        s_in,
    input  logic [7:0]        d_in,
    output logic [DIV_NW-1:0] num_out,
    output logic [DIV_DW-1:0] den_out,
    output logic              direct_out,
    output logic [7:0]        dval_out,
    output logic              flip_out
);

    logic [3:0]  mode_reg [1:3];
    logic [7:0]  s_reg    [1:3];
    logic [7:0]  d_reg    [1:3];
    logic [15:0] sd_reg   [1:3];
    logic [15:0] cc_reg   [1:3];
    logic [15:0] dd_reg   [1:2];
    logic [15:0] dm_reg;
    logic [7:0]  qd_reg   [1:2];
    logic [23:0] d3_reg;
    logic [23:0] slp_reg  [2:3];
    logic [22:0] tm_reg;

    logic [7:0]  f_lo;
    logic [29:0] tm_next;
    logic [32:0] n_next;
    logic [23:0] m_next;
    logic        direct_next;
    logic [7:0]  dval_next;
    logic        flip_next;
    logic [8:0]  sum9;
    logic [8:0]  s2m;
    logic [7:0]  sel;

    assign f_lo = 8'd255 - {s_reg[1][6:0], 1'b0};

    always_comb begin
        if (d_reg[2] < 8'd64) begin
            tm_next = (30'(d3_reg) << 4) + 30'(d_reg[2]) * 30'd195075
                      - 30'(dd_reg[2]) * 30'd3060;
        end else begin
            tm_next = 30'(qd_reg[2] - d_reg[2]) * 30'd65025;
        end
    end

    always_comb begin
        n_next      = '0;
        m_next      = 24'd255;
        direct_next = 1'b0;
        dval_next   = s_reg[3];
        flip_next   = 1'b0;
        sum9        = {1'b0, s_reg[3]} + {1'b0, d_reg[3]};
        s2m         = {s_reg[3], 1'b0} - 9'd255;
        sel         = (mode_reg[3] == MODE_OVERLAY) ? d_reg[3] : s_reg[3];
        case (mode_reg[3])
            MODE_MULTIPLY: begin
                n_next = 33'(sd_reg[3]);
            end
            MODE_OVERLAY, MODE_HARD: begin
                if (!sel[7]) begin
                    n_next = 33'(sd_reg[3]) << 1;
                end else begin
                    n_next    = 33'(cc_reg[3]) << 1;
                    flip_next = 1'b1;
                end
            end
            MODE_SCREEN: begin
                n_next    = 33'(cc_reg[3]);
                flip_next = 1'b1;
            end
            MODE_DARKEN: begin
                direct_next = 1'b1;
                dval_next   = (s_reg[3] < d_reg[3]) ? s_reg[3] : d_reg[3];
            end
            MODE_LIGHTEN: begin
                direct_next = 1'b1;
                dval_next   = (s_reg[3] > d_reg[3]) ? s_reg[3] : d_reg[3];
            end
            MODE_DODGE: begin
                if (s_reg[3] == 8'd255) begin
                    direct_next = 1'b1;
                    dval_next   = 8'd255;
                end else begin
                    n_next = 33'(d_reg[3]) * 33'd255;
                    m_next = 24'(8'd255 - s_reg[3]);
                end
            end
            MODE_BURN: begin
                if (s_reg[3] == 8'd0 || sum9 <= 9'd255) begin
                    direct_next = 1'b1;
                    dval_next   = 8'd0;
                end else begin
                    n_next = 33'(sum9 - 9'd255) * 33'd255;
                    m_next = 24'(s_reg[3]);
                end
            end
            MODE_SOFT: begin
                if (!s_reg[3][7]) begin
                    n_next = 33'(d_reg[3]) * 33'd65025 - 33'(slp_reg[3]);
                    m_next = 24'd65025;
                end else begin
                    n_next = 33'(d_reg[3]) * 33'd16581375
                             + 33'(s2m[7:0]) * 33'(tm_reg);
                    m_next = 24'd16581375;
                end
            end
            MODE_DIFF: begin
                direct_next = 1'b1;
                dval_next   = (s_reg[3] > d_reg[3]) ? s_reg[3] - d_reg[3]
                                                     : d_reg[3] - s_reg[3];
            end
            MODE_EXCL: begin
                n_next = 33'(sum9) * 33'd255 - (33'(sd_reg[3]) << 1);
            end
            default: begin
                direct_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            mode_reg[1] <= mode_in;
            s_reg[1]    <= s_in;
            d_reg[1]    <= d_in;
            sd_reg[1]   <= 16'(s_in) * 16'(d_in);
            cc_reg[1]   <= 16'(8'd255 - s_in) * 16'(8'd255 - d_in);
            dd_reg[1]   <= 16'(d_in) * 16'(d_in);
            dm_reg      <= 16'(d_in) * 16'(8'd255 - d_in);
            qd_reg[1]   <= SQRT_LUT[d_in];
        end
        if (load[2]) begin
            mode_reg[2] <= mode_reg[1];
            s_reg[2]    <= s_reg[1];
            d_reg[2]    <= d_reg[1];
            sd_reg[2]   <= sd_reg[1];
            cc_reg[2]   <= cc_reg[1];
            dd_reg[2]   <= dd_reg[1];
            qd_reg[2]   <= qd_reg[1];
            d3_reg      <= 24'(dd_reg[1]) * 24'(d_reg[1]);
            slp_reg[2]  <= 24'(f_lo) * 24'(dm_reg);
        end
        if (load[3]) begin
            mode_reg[3] <= mode_reg[2];
            s_reg[3]    <= s_reg[2];
            d_reg[3]    <= d_reg[2];
            sd_reg[3]   <= sd_reg[2];
            cc_reg[3]   <= cc_reg[2];
            slp_reg[3]  <= slp_reg[2];
            tm_reg      <= tm_next[22:0];
        end
        if (load[4]) begin
            num_out    <= DIV_NW'({n_next, 1'b0}) + DIV_NW'(m_next);
            den_out    <= DIV_DW'({m_next, 1'b0});
            direct_out <= direct_next;
            dval_out   <= dval_next;
            flip_out   <= flip_next;
        end
    end

endmodule

`default_nettype wire

### design/pbm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbm_div
// Four-stage restoring divider, two quotient bits per stage, 8-bit quotient
// that saturates to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_div import pbm_pkg::*; (
    input  logic              aclk,
    input  logic [3:0]        load,
    input  logic [DIV_NW-1:0] num_in,
    input  logic [DIV_DW-1:0] den_in,
    output logic [7:0]        quo
);

    logic [DIV_NW-1:0] rem_reg [0:2];
    logic [DIV_DW-1:0] den_reg [0:2];
    logic [7:0]        q_reg   [0:3];
    logic              sat_reg [0:3];

    for (genvar j = 0; j < 4; j++) begin : g_stage
        logic [DIV_NW-1:0] r_in;
        logic [DIV_NW-1:0] r_mid;
        logic [DIV_NW-1:0] r_out;
        logic [DIV_DW-1:0] d_in;
        logic [7:0]        q_in;
        logic [7:0]        q_out;
        logic              sat_in;
        logic [DIV_NW-1:0] sh_hi;
        logic [DIV_NW-1:0] sh_lo;

        if (j == 0) begin : g_first
            assign r_in   = num_in;
            assign d_in   = den_in;
            assign q_in   = '0;
            assign sat_in = num_in >= (DIV_NW'(den_in) << 8);
        end else begin : g_next
            assign r_in   = rem_reg[j-1];
            assign d_in   = den_reg[j-1];
            assign q_in   = q_reg[j-1];
            assign sat_in = sat_reg[j-1];
        end

        assign sh_hi = DIV_NW'(d_in) << (7 - 2 * j);
        assign sh_lo = DIV_NW'(d_in) << (6 - 2 * j);

        always_comb begin
            q_out = q_in;
            r_mid = r_in;
            if (r_in >= sh_hi) begin
                r_mid            = r_in - sh_hi;
                q_out[7 - 2 * j] = 1'b1;
            end
            r_out = r_mid;
            if (r_mid >= sh_lo) begin
                r_out            = r_mid - sh_lo;
                q_out[6 - 2 * j] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (load[j]) begin
                q_reg[j]   <= q_out;
                sat_reg[j] <= sat_in;
            end
        end

        if (j < 3) begin : g_carry
            always_ff @(posedge aclk) begin
                if (load[j]) begin
                    rem_reg[j] <= r_out;
                    den_reg[j] <= d_in;
                end
            end
        end
    end

    assign quo = sat_reg[3] ? 8'hFF : q_reg[3];

endmodule

`default_nettype wire

### design/pixel_blend_mode_compositor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_blend_mode_compositor_core
// Separable blend modes with non-premultiplied source-over compositing.
// Pipeline: the blend divider and the source-over divider, four stages each,
// plus the operand and output stages.
// Throughput: one pixel pair per cycle while m_ready is high or a bubble remains; bubbles absorb a stalled output.
// Reset: clears the pipeline valid bits, layer_mode to normal, opacity to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_blend_mode_compositor_core import pbm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  pbm_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output pbm_out_t    m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [3:0] layer_mode_reg;
    logic [7:0] opacity_reg;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_mode_reg <= RESET_LAYER_MODE;
            opacity_reg    <= RESET_OPACITY;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_LAYER_MODE: layer_mode_reg <= pwdata[3:0];
                REG_OPACITY:    opacity_reg    <= pwdata[7:0];
                default:        layer_mode_reg <= layer_mode_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LAYER_MODE: prdata = {28'b0, layer_mode_reg};
            REG_OPACITY:    prdata = {24'b0, opacity_reg};
            default:        prdata = '0;
        endcase
    end

    logic [NUM_STAGES:1] load;

    pbm_flow u_flow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .load    (load)
    );

    logic [7:0] src_col [3];
    logic [7:0] dst_col [3];

    assign src_col[0] = s_data.src_red;
    assign src_col[1] = s_data.src_green;
    assign src_col[2] = s_data.src_blue;
    assign dst_col[0] = s_data.dst_red;
    assign dst_col[1] = s_data.dst_green;
    assign dst_col[2] = s_data.dst_blue;

    logic [3:0]  mode_reg  [1:2];
    logic [7:0]  da_reg    [1:2];
    logic [15:0] psa_reg;
    logic [15:0] dc_reg    [1:2][3];
    logic [7:0]  dcol_reg  [1:2][3];
    logic [7:0]  addc_reg  [1:2][3];
    logic [7:0]  sa_reg    [2:8];
    logic [15:0] daia_reg;
    logic [23:0] ddx_reg   [3:9][3];
    logic [15:0] a_reg     [4:9];
    logic        byp_reg   [3:14];
    pbm_out_t    bpix_reg  [3:14];
    logic [7:0]  aout_reg  [5:14];
    logic        zero_reg  [5:14];
    logic        dir_reg   [5:8][3];
    logic [7:0]  dval_reg  [5:8][3];
    logic        flip_reg  [5:8][3];
    logic [15:0] bsa_reg   [3];
    logic [25:0] fn_reg    [3];
    logic [16:0] fd_reg    [3];
    pbm_out_t    m_data_reg;

    logic [DIV_NW-1:0] mnum [3];
    logic [DIV_DW-1:0] mden [3];
    logic              mdir [3];
    logic [7:0]        mdval [3];
    logic              mflip [3];
    logic [7:0]        mq   [3];
    logic [7:0]        fq   [3];
    logic [7:0]        b9   [3];
    logic [24:0]       fsum [3];

    for (genvar c = 0; c < 3; c++) begin : g_lane
        pbm_mix u_mix (
            .aclk       (aclk),
            .load       (load[4:1]),
            .mode_in    (layer_mode_reg),
            .s_in       (src_col[c]),
            .d_in       (dst_col[c]),
            .num_out    (mnum[c]),
            .den_out    (mden[c]),
            .direct_out (mdir[c]),
            .dval_out   (mdval[c]),
            .flip_out   (mflip[c])
        );

        pbm_div u_mix_div (
            .aclk   (aclk),
            .load   (load[8:5]),
            .num_in (mnum[c]),
            .den_in (mden[c]),
            .quo    (mq[c])
        );

        pbm_div u_over_div (
            .aclk   (aclk),
            .load   (load[14:11]),
            .num_in (DIV_NW'(fn_reg[c])),
            .den_in (DIV_DW'(fd_reg[c])),
            .quo    (fq[c])
        );

        assign b9[c] = dir_reg[8][c]  ? dval_reg[8][c] :
                       flip_reg[8][c] ? 8'd255 - mq[c] : mq[c];

        assign fsum[c] = 25'({bsa_reg[c], 8'b0}) - 25'(bsa_reg[c]) + 25'(ddx_reg[9][c]);
    end

    logic [7:0]  ia2;
    pbm_out_t    bpix_next;
    logic [15:0] a_next;

    assign ia2    = 8'd255 - sa_reg[2];
    assign a_next = {sa_reg[3], 8'b0} - 16'(sa_reg[3]) + daia_reg;

    // add and erase bypass the blend and source-over path
    always_comb begin
        if (mode_reg[2] == MODE_ADD) begin
            bpix_next.out_red   = addc_reg[2][0];
            bpix_next.out_green = addc_reg[2][1];
            bpix_next.out_blue  = addc_reg[2][2];
            bpix_next.out_alpha = sat_add8(sa_reg[2], da_reg[2]);
        end else begin
            bpix_next.out_red   = dcol_reg[2][0];
            bpix_next.out_green = dcol_reg[2][1];
            bpix_next.out_blue  = dcol_reg[2][2];
            bpix_next.out_alpha = (da_reg[2] > sa_reg[2]) ? da_reg[2] - sa_reg[2] : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load[1]) begin
            mode_reg[1] <= layer_mode_reg;
            da_reg[1]   <= s_data.dst_alpha;
            psa_reg     <= 16'(s_data.src_alpha) * 16'(opacity_reg);
            for (int c = 0; c < 3; c++) begin
                dc_reg[1][c]   <= 16'(dst_col[c]) * 16'(s_data.dst_alpha);
                dcol_reg[1][c] <= dst_col[c];
                addc_reg[1][c] <= sat_add8(src_col[c], dst_col[c]);
            end
        end
        if (load[2]) begin
            mode_reg[2] <= mode_reg[1];
            da_reg[2]   <= da_reg[1];
            sa_reg[2]   <= div255(17'(psa_reg) + 17'd127);
            for (int c = 0; c < 3; c++) begin
                dc_reg[2][c]   <= dc_reg[1][c];
                dcol_reg[2][c] <= dcol_reg[1][c];
                addc_reg[2][c] <= addc_reg[1][c];
            end
        end
        if (load[3]) begin
            sa_reg[3]   <= sa_reg[2];
            daia_reg    <= 16'(da_reg[2]) * 16'(ia2);
            byp_reg[3]  <= (mode_reg[2] == MODE_ADD) || (mode_reg[2] == MODE_ERASE);
            bpix_reg[3] <= bpix_next;
            for (int c = 0; c < 3; c++) begin
                ddx_reg[3][c] <= 24'(dc_reg[2][c]) * 24'(ia2);
            end
        end
        if (load[4]) begin
            a_reg[4] <= a_next;
        end
        if (load[5]) begin
            aout_reg[5] <= div255(17'(a_reg[4]) + 17'd127);
            zero_reg[5] <= (a_reg[4] == 16'd0);
            for (int c = 0; c < 3; c++) begin
                dir_reg[5][c]  <= mdir[c];
                dval_reg[5][c] <= mdval[c];
                flip_reg[5][c] <= mflip[c];
            end
        end
        for (int k = 4; k <= 8; k++) begin
            if (load[k]) begin
                sa_reg[k] <= sa_reg[k-1];
            end
        end
        for (int k = 4; k <= 9; k++) begin
            if (load[k]) begin
                for (int c = 0; c < 3; c++) begin
                    ddx_reg[k][c] <= ddx_reg[k-1][c];
                end
            end
        end
        for (int k = 5; k <= 9; k++) begin
            if (load[k]) begin
                a_reg[k] <= a_reg[k-1];
            end
        end
        for (int k = 4; k <= 14; k++) begin
            if (load[k]) begin
                byp_reg[k]  <= byp_reg[k-1];
                bpix_reg[k] <= bpix_reg[k-1];
            end
        end
        for (int k = 6; k <= 14; k++) begin
            if (load[k]) begin
                aout_reg[k] <= aout_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
        for (int k = 6; k <= 8; k++) begin
            if (load[k]) begin
                for (int c = 0; c < 3; c++) begin
                    dir_reg[k][c]  <= dir_reg[k-1][c];
                    dval_reg[k][c] <= dval_reg[k-1][c];
                    flip_reg[k][c] <= flip_reg[k-1][c];
                end
            end
        end
        if (load[9]) begin
            for (int c = 0; c < 3; c++) begin
                bsa_reg[c] <= 16'(b9[c]) * 16'(sa_reg[8]);
            end
        end
        if (load[10]) begin
            for (int c = 0; c < 3; c++) begin
                fn_reg[c] <= 26'({fsum[c], 1'b0}) + 26'(a_reg[9]);
                fd_reg[c] <= {a_reg[9], 1'b0};
            end
        end
        if (load[15]) begin
            if (byp_reg[14]) begin
                m_data_reg <= bpix_reg[14];
            end else if (zero_reg[14]) begin
                m_data_reg <= '0;
            end else begin
                m_data_reg.out_red   <= fq[0];
                m_data_reg.out_green <= fq[1];
                m_data_reg.out_blue  <= fq[2];
                m_data_reg.out_alpha <= aout_reg[14];
            end
        end
    end

    assign m_data = m_data_reg;

endmodule

`default_nettype wire

### verif/pixel_blend_mode_compositor_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_blend_mode_compositor_core_test
// Drives pixel pairs through the compositor under random burst and stall
// patterns, across blend modes and opacity settings, and compares every
// output transfer with a fixed-point predictor of the blend and source-over.
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_blend_mode_compositor_core_test;
    import pbm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LATENCY = 15;
    localparam int RANDOM_PIXELS = 1800;
    localparam logic [2:0] ADDR_LAYER_MODE = 3'd0;
    localparam logic [2:0] ADDR_OPACITY = 3'd4;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    pbm_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    pbm_out_t    m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [3:0] cur_mode;
    logic [7:0] cur_opacity;
    pbm_out_t   pending_pixels[$];
    int         errors;
    int         cycles;

    typedef struct {
        pbm_in_t  px;
        bit       has_out;
        pbm_out_t out;
    } dir_row_t;

    pixel_blend_mode_compositor_core dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic longint unsigned rdiv(longint unsigned n, longint unsigned m);
        return (2 * n + m) / (2 * m);
    endfunction

    function automatic longint unsigned sat(longint unsigned v);
        return v > 255 ? 255 : v;
    endfunction

    function automatic longint unsigned root_code(longint unsigned i);
        longint unsigned v;
        longint unsigned r;
        v = 255 * i;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        if (v - r * r > r) r++;
        return r;
    endfunction

    function automatic longint unsigned blend_channel(logic [3:0] m, longint unsigned s,
                                                      longint unsigned d);
        longint unsigned t;
        longint unsigned sel;
        case (m)
            MODE_MULTIPLY: return rdiv(s * d, 255);
            MODE_OVERLAY, MODE_HARD: begin
                sel = (m == MODE_OVERLAY) ? d : s;
                if (sel <= 127) return rdiv(2 * s * d, 255);
                return 255 - rdiv(2 * (255 - s) * (255 - d), 255);
            end
            MODE_SCREEN: return 255 - rdiv((255 - s) * (255 - d), 255);
            MODE_DARKEN: return s < d ? s : d;
            MODE_LIGHTEN: return s > d ? s : d;
            MODE_DODGE: begin
                if (s == 255) return 255;
                return sat(rdiv(255 * d, 255 - s));
            end
            MODE_BURN: begin
                if (s == 0 || 255 * s <= 255 * (255 - d)) return 0;
                return sat(rdiv(255 * s - 255 * (255 - d), s));
            end
            MODE_SOFT: begin
                if (s <= 127)
                    return sat(rdiv(65025 * d - (255 - 2 * s) * d * (255 - d), 65025));
                if (d <= 63) t = 16 * d * d * d + 260100 * d - 3060 * d * d;
                else t = 65025 * root_code(d);
                // t >= 65025d here, so the product stays non-negative
                return sat(rdiv(16581375 * d + (2 * s - 255) * (t - 65025 * d), 16581375));
            end
            MODE_DIFF: return s > d ? s - d : d - s;
            MODE_EXCL: return sat(rdiv(255 * (s + d) - 2 * s * d, 255));
            default: return s;
        endcase
    endfunction

    function automatic pbm_out_t composite_pixel(pbm_in_t px);
        pbm_out_t        o;
        longint unsigned s[3];
        longint unsigned d[3];
        longint unsigned sa;
        longint unsigned da;
        longint unsigned a_num;
        longint unsigned b;
        s = '{px.src_red, px.src_green, px.src_blue};
        d = '{px.dst_red, px.dst_green, px.dst_blue};
        da = px.dst_alpha;
        sa = rdiv(longint'(px.src_alpha) * cur_opacity, 255);
        if (cur_mode == MODE_ADD) begin
            o.out_red = 8'(sat(s[0] + d[0]));
            o.out_green = 8'(sat(s[1] + d[1]));
            o.out_blue = 8'(sat(s[2] + d[2]));
            o.out_alpha = 8'(sat(sa + da));
            return o;
        end
        if (cur_mode == MODE_ERASE) begin
            o.out_red = px.dst_red;
            o.out_green = px.dst_green;
            o.out_blue = px.dst_blue;
            o.out_alpha = 8'(da > sa ? da - sa : 0);
            return o;
        end
        a_num = 255 * sa + da * (255 - sa);
        if (a_num == 0) return '0;
        b = blend_channel(cur_mode, s[0], d[0]);
        o.out_red = 8'(sat(rdiv(255 * b * sa + d[0] * da * (255 - sa), a_num)));
        b = blend_channel(cur_mode, s[1], d[1]);
        o.out_green = 8'(sat(rdiv(255 * b * sa + d[1] * da * (255 - sa), a_num)));
        b = blend_channel(cur_mode, s[2], d[2]);
        o.out_blue = 8'(sat(rdiv(255 * b * sa + d[2] * da * (255 - sa), a_num)));
        o.out_alpha = 8'(sat(rdiv(a_num, 255)));
        return o;
    endfunction

    // receiver: stall pattern of its own, check each output transfer
    initial begin
        int stall_mode;
        pbm_out_t want;
        m_ready = 1'b0;
        stall_mode = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel, expected none, actual %h", $time, m_data);
                    errors++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_data.out_red !== want.out_red) begin
                        $display("%0t: out_red expected %0d actual %0d", $time,
                                 want.out_red, m_data.out_red);
                        errors++;
                    end
                    if (m_data.out_green !== want.out_green) begin
                        $display("%0t: out_green expected %0d actual %0d", $time,
                                 want.out_green, m_data.out_green);
                        errors++;
                    end
                    if (m_data.out_blue !== want.out_blue) begin
                        $display("%0t: out_blue expected %0d actual %0d", $time,
                                 want.out_blue, m_data.out_blue);
                        errors++;
                    end
                    if (m_data.out_alpha !== want.out_alpha) begin
                        $display("%0t: out_alpha expected %0d actual %0d", $time,
                                 want.out_alpha, m_data.out_alpha);
                        errors++;
                    end
                end
            end
            if (cycles % 200 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (cycles % 7) < 4;
            endcase
        end
    end

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_LAYER_MODE) cur_mode = value[3:0];
        else cur_opacity = value[7:0];
        @(posedge aclk);
    endtask

    task automatic drain_pipeline();
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY + 5) @(posedge aclk);
    endtask

    // sender: holds valid until the transfer, then queues the table row or the prediction
    task automatic send_pixel(pbm_in_t px, bit has_out, pbm_out_t fixed_out);
        pbm_out_t pred;
        s_valid <= 1'b1;
        s_data <= px;
        do @(posedge aclk); while (!s_ready);
        pred = composite_pixel(px);
        if (has_out && pred !== fixed_out) begin
            $display("%0t: table row expected %h, predictor %h", $time, fixed_out, pred);
            errors++;
        end
        pending_pixels.push_back(has_out ? fixed_out : pred);
    endtask

    function automatic pbm_in_t random_pixel();
        pbm_in_t px;
        int k;
        px = pbm_in_t'({$urandom, $urandom});
        k = $urandom_range(0, 9);
        if (k == 0) px.src_alpha = 8'd0;
        if (k == 1) px.dst_alpha = 8'd0;
        if (k == 2) begin
            px.src_alpha = 8'd0;
            px.dst_alpha = 8'd0;
        end
        if (k == 3) px = $urandom_range(0, 1) ? '1 : '0;
        return px;
    endfunction

    initial begin
        dir_row_t rows[$];
        int       burst;
        int       n;
        logic [7:0] opac_set[6];
        errors = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cur_mode = RESET_LAYER_MODE;
        cur_opacity = RESET_OPACITY;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows under reset settings (normal, full opacity)
        rows.push_back('{64'h0000000000000000, 1, 32'h00000000});
        rows.push_back('{64'hFFFFFFFFFFFFFFFF, 1, 32'hFFFFFFFF});
        rows.push_back('{64'h102030FF_40506070, 1, 32'h102030FF});
        rows.push_back('{64'h10203000_405060FF, 1, 32'h405060FF});
        rows.push_back('{64'h10203000_40506000, 1, 32'h00000000});
        rows.push_back('{64'h80FF00C0_FF0080A0, 0, '0});
        rows.push_back('{64'h7F807F40_807F8033, 0, '0});
        foreach (rows[i]) begin
            send_pixel(rows[i].px, rows[i].has_out, rows[i].out);
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        drain_pipeline();

        // every mode code, unused ones included, on a few edge pixels
        for (int m = 0; m < 16; m++) begin
            write_reg(ADDR_LAYER_MODE, 32'(m));
            send_pixel(64'h00FF7FFF_FF0080C0, 0, '0);
            send_pixel(64'hFF0080C8_7F40FF00, 0, '0);
            s_valid <= 1'b0;
            drain_pipeline();
        end

        opac_set = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd254, 8'd77};
        n = 0;
        while (n < RANDOM_PIXELS) begin
            if (n % 90 == 0) begin
                s_valid <= 1'b0;
                drain_pipeline();
                write_reg(ADDR_LAYER_MODE, {4'($urandom_range(0, 15)), 28'h0});
                write_reg(ADDR_LAYER_MODE, 32'($urandom_range(0, 15)));
                write_reg(ADDR_OPACITY, $urandom_range(0, 3) == 0 ?
                          32'(opac_set[$urandom_range(0, 5)]) : $urandom);
            end
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst; b++) begin
                send_pixel(random_pixel(), 0, '0);
                n++;
            end
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;
        drain_pipeline();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
